FILE: rtl/tctw_pkg.sv
package tctw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] ATTR_RESET = 8'd7;
    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } item_in_t;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic [10:0] cursor_pos;
        logic        scrolled;
    } item_out_t;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_READ_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  code;
        logic [7:0]  attr;
        logic [10:0] index;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } back_state_t;

endpackage

FILE: rtl/tctw_front.sv
module tctw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tctw_pkg::item_in_t cmd,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               queue_full,
    input  logic               clearing,
    output logic               busy,
    output logic               push,
    output tctw_pkg::cmd_t     push_cmd
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [7:0] attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tctw_pkg::ATTR_RESET;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_data;
        end
    end

    assign busy = queue_full | clearing;
    assign push = start & ~busy;

    always_comb
    begin
        push_cmd.code = cmd.char_code;
        push_cmd.attr = attr_reg;
        push_cmd.index = cmd.cell_index;
        if (cmd.kind == tctw_pkg::KIND_READ)
        begin
            if (32'(cmd.cell_index) < 32'(CELLS))
            begin
                push_cmd.op = tctw_pkg::OP_READ;
            end
            else
            begin
                push_cmd.op = tctw_pkg::OP_READ_NONE;
            end
        end
        else if (cmd.char_code == tctw_pkg::NEWLINE_CODE)
        begin
            push_cmd.op = tctw_pkg::OP_NEWLINE;
        end
        else
        begin
            push_cmd.op = tctw_pkg::OP_PUT;
        end
    end

endmodule

FILE: rtl/tctw_queue.sv
module tctw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tctw_pkg::cmd_t push_cmd,
    input  logic           pop,
    output tctw_pkg::cmd_t head,
    output logic           avail,
    output logic           full
);

    tctw_pkg::cmd_t entries_reg [tctw_pkg::QUEUE_DEPTH];
    logic [tctw_pkg::QUEUE_PW-1:0] wr_ptr_reg;
    logic [tctw_pkg::QUEUE_PW-1:0] rd_ptr_reg;
    logic [tctw_pkg::QUEUE_CW-1:0] count_reg;
    logic [tctw_pkg::QUEUE_CW-1:0] count_next;

    assign head = entries_reg[rd_ptr_reg];
    assign avail = (count_reg != '0);
    assign full = (count_reg == tctw_pkg::QUEUE_CW'(tctw_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/tctw_back.sv
module tctw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tctw_pkg::cmd_t      head,
    input  logic                avail,
    output logic                pop,
    output logic                clearing,
    output tctw_pkg::item_out_t result,
    output logic                done
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LAST_BASE = CELLS - COLUMNS;
    localparam int AW = $clog2(CELLS);
    localparam int AW1 = AW + 1;
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    tctw_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] lin_reg, lin_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    tctw_pkg::item_out_t res_reg, res_next;
    logic done_reg, done_next;

    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0] wr_data;

    logic          wrap;
    logic [AW1-1:0] src;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tctw_pkg::ST_CLEAR;
            ptr_reg <= '0;
            lin_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            lin_reg <= lin_next;
            col_reg <= col_next;
            row_reg <= row_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        lin_next = lin_reg;
        col_next = col_reg;
        row_next = row_reg;
        res_next = res_reg;
        done_next = 1'b0;
        pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = ptr_reg;
        wr_data = '0;
        wrap = (head.op == tctw_pkg::OP_NEWLINE) || (col_reg == CW'(COLUMNS - 1));
        src = AW1'(ptr_reg) + AW1'(COLUMNS + 1);

        unique case (state_reg)
            tctw_pkg::ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next = '0;
                    state_next = tctw_pkg::ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            tctw_pkg::ST_IDLE:
            begin
                if (avail)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        tctw_pkg::OP_READ:
                        begin
                            rd_en = 1'b1;
                            rd_addr = AW'(head.index);
                            state_next = tctw_pkg::ST_READ;
                        end
                        tctw_pkg::OP_READ_NONE:
                        begin
                            res_next = '{8'd0, 8'd0, 11'(lin_reg), 1'b0};
                            done_next = 1'b1;
                        end
                        tctw_pkg::OP_PUT, tctw_pkg::OP_NEWLINE:
                        begin
                            if (head.op == tctw_pkg::OP_PUT)
                            begin
                                wr_en = 1'b1;
                                wr_addr = lin_reg;
                                wr_data = {head.code, head.attr};
                            end
                            if (wrap && (row_reg == RW'(ROWS - 1)))
                            begin
                                lin_next = AW'(LAST_BASE);
                                col_next = '0;
                                rd_en = 1'b1;
                                rd_addr = AW'(COLUMNS);
                                ptr_next = '0;
                                state_next = tctw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                if (wrap)
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                                if (head.op == tctw_pkg::OP_NEWLINE)
                                begin
                                    lin_next = lin_reg + AW'(COLUMNS) - AW'(col_reg);
                                end
                                else
                                begin
                                    lin_next = lin_reg + 1'b1;
                                end
                                res_next = '{8'd0, 8'd0, 11'(lin_next), 1'b0};
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = tctw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tctw_pkg::ST_READ:
            begin
                res_next = '{rd_data_reg[15:8], rd_data_reg[7:0], 11'(lin_reg), 1'b0};
                done_next = 1'b1;
                state_next = tctw_pkg::ST_IDLE;
            end
            tctw_pkg::ST_SCROLL:
            begin
                wr_en = 1'b1;
                if (ptr_reg < AW'(LAST_BASE))
                begin
                    wr_data = rd_data_reg;
                end
                if (src < AW1'(CELLS))
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(src);
                end
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next = '0;
                    res_next = '{8'd0, 8'd0, 11'(lin_reg), 1'b1};
                    done_next = 1'b1;
                    state_next = tctw_pkg::ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tctw_pkg::ST_IDLE;
            end
        endcase
    end

    assign clearing = (state_reg == tctw_pkg::ST_CLEAR);
    assign result = res_reg;
    assign done = done_reg;

endmodule

FILE: rtl/text_console_teletype_writer.sv
// Teletype writer for a COLUMNS x ROWS character-cell screen with a linear cursor.
// An item is transferred at a rising edge where start is high and busy is low.
// A put item writes a character with the configured attribute, or moves to the
// next row for a newline; a read item returns one screen cell, or zeros when out of range.
// Each item gives exactly one result, shown on result for one cycle with done
// high; the receiver must take it then, as it cannot hold results off.
// done is registered: the queue hands the item to the writer, which raises done for
// puts and out-of-range reads; an in-range read first reads the screen memory, which
// has a registered read port beside its write port.
// A two-entry queue lets new items be taken while the writer works; busy rises
// only when it is full or while the screen is cleared. A scroll holds the writer
// while it walks all COLUMNS*ROWS cells, one memory cell moved or cleared per
// cycle, and its done rises at the end of the walk.
// cfg_we and cfg_data write the attribute byte (reset value 7); the user is to write it
// only while idle, which the block itself does not enforce. After reset busy stays high
// while the COLUMNS*ROWS cells are cleared to zeros; the cursor resets to cell zero.
module text_console_teletype_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tctw_pkg::item_in_t  cmd,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    output tctw_pkg::item_out_t result,
    output logic                done
);

    localparam int CELLS = COLUMNS * ROWS;

    logic           push;
    tctw_pkg::cmd_t push_cmd;
    logic           pop;
    tctw_pkg::cmd_t head;
    logic           avail;
    logic           queue_full;
    logic           clearing;

    tctw_front #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .queue_full(queue_full),
        .clearing(clearing),
        .busy(busy),
        .push(push),
        .push_cmd(push_cmd)
    );

    tctw_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_cmd(push_cmd),
        .pop(pop),
        .head(head),
        .avail(avail),
        .full(queue_full)
    );

    tctw_back #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .avail(avail),
        .pop(pop),
        .clearing(clearing),
        .result(result),
        .done(done)
    );

`ifndef NO_ASSERTIONS
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.cursor_pos) < 32'(CELLS)))
        else $error("cursor left the screen");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_pos == 11'(CELLS - COLUMNS)))
        else $error("scroll did not leave the cursor at the last row start");

    a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.read_char != 8'd0 || result.read_attr != 8'd0))
            |-> !result.scrolled)
        else $error("read data returned with a scroll");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (busy && !done))
        else $error("transfer possible while screen is being cleared");
`endif

endmodule
